FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define VFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that ante on one edge gives cons on the next
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Check that ante gives cons after the delay that n gives
`define VFA_ASSERT_DELAY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);
`else
`define VFA_ASSERT(lbl, prop, msg)
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg)
`define VFA_ASSERT_DELAY(lbl, ante, n, cons, msg)
`endif
`endif

FILE: hw/rtl/vfa_pkg.sv
// ---------------------------------------------------------------------------
// vfa_pkg
// Types, command codes and the saturating clamp of the vector ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package vfa_pkg;

    localparam int FIELD_W            = 32;
    localparam int COMPONENT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF      = 16;
    localparam int ROOT_W             = 33;  // floor(sqrt(2^64)) needs 33 bits
    localparam int SUMSQ_W            = 65;
    localparam int SQREM_W            = 67;
    localparam int WIDE_W             = 72;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_SCALE = 3'd2,
        CMD_MUL   = 3'd3,
        CMD_DOT   = 3'd4,
        CMD_MAG   = 3'd5,
        CMD_NORM  = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [2:0]                cmd;
        logic signed [FIELD_W-1:0] a_x;
        logic signed [FIELD_W-1:0] a_y;
        logic signed [FIELD_W-1:0] a_z;
        logic signed [FIELD_W-1:0] a_w;
        logic signed [FIELD_W-1:0] b_x;
        logic signed [FIELD_W-1:0] b_y;
        logic signed [FIELD_W-1:0] b_z;
        logic signed [FIELD_W-1:0] b_w;
        logic signed [FIELD_W-1:0] scale_factor;
    } in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] r_x;
        logic signed [FIELD_W-1:0] r_y;
        logic signed [FIELD_W-1:0] r_z;
        logic signed [FIELD_W-1:0] r_w;
        logic signed [FIELD_W-1:0] scalar_out;
        logic                      saturated;
    } out_t;

    // Everything an item drags along the pipeline
    typedef struct packed {
        logic [2:0]               cmd;
        logic [3:0][FIELD_W-1:0]  a;
        logic [3:0][FIELD_W-1:0]  r;
        logic [FIELD_W-1:0]       s;
        logic                     sat;
    } carry_t;

    // Clamp to the signed cb-bit range; returns {clamped, low field bits}
    function automatic logic [FIELD_W:0] sat_clamp(input logic signed [WIDE_W-1:0] v,
                                                   input int cb);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed((WIDE_W'(1) << (cb - 1)) - WIDE_W'(1));
        lo = -hi - WIDE_W'(1);
        if (v > hi)
        begin
            return {1'b1, hi[FIELD_W-1:0]};
        end
        else if (v < lo)
        begin
            return {1'b1, lo[FIELD_W-1:0]};
        end
        return {1'b0, v[FIELD_W-1:0]};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vec4_fixed_point_alu_core.sv
// ---------------------------------------------------------------------------
// vec4_fixed_point_alu_core
// Four-lane fixed-point vector ALU: add, sub, scale, product, dot,
// magnitude and normalize, all saturating.
// ---------------------------------------------------------------------------
// One beat enters per cycle (busy is always low) and its result appears on
// rsp with done high for one cycle; every command takes the same path. After
// the input, product and result registers the item runs through the square-root
// pipeline (one root bit per stage) and then the four-lane divider of
// normalize (one quotient bit per stage), then the output register; the
// faster commands ride the same pipeline so results leave in order. The
// receiver cannot stall, so a result must be taken in its cycle.
`default_nettype none
`include "assert_macros.svh"

module vec4_fixed_point_alu_core #(
    parameter int COMPONENT_BITS = vfa_pkg::COMPONENT_BITS_DEF,
    parameter int FRAC_BITS      = vfa_pkg::FRAC_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire vfa_pkg::in_t  req,
    output logic               done,
    output vfa_pkg::out_t      rsp
);
    import vfa_pkg::*;

    localparam int NUM_W = FIELD_W + FRAC_BITS;
    localparam int LAT   = 6 + ROOT_W + NUM_W;

    // stage 1: input register
    logic       s1_v_reg;
    in_t        s1_reg;
    logic signed [FIELD_W-1:0] a1 [4];
    logic signed [FIELD_W-1:0] b1 [4];
    logic signed [FIELD_W-1:0] bsel [4];

    // stage 2: products and sums
    logic                      s2_v_reg;
    logic [2:0]                s2_cmd_reg;
    logic [3:0][FIELD_W-1:0]   s2_a_reg;
    logic signed [63:0]        s2_prod_reg [4];
    logic [62:0]               s2_sq_reg [4];
    logic signed [FIELD_W:0]   s2_sum_reg [4];
    logic signed [63:0]        s2_prod_next [4];
    logic signed [63:0]        s2_sq_full [4];
    logic [62:0]               s2_sq_next [4];
    logic signed [FIELD_W:0]   s2_sum_next [4];

    // stage 3: vector results, dot sum, sum of squares
    logic                      s3_v_reg;
    carry_t                    s3_reg;
    logic signed [65:0]        s3_dot_reg;
    logic [SUMSQ_W-1:0]        s3_sumsq_reg;
    carry_t                    s3_next;
    logic signed [65:0]        s3_dot_next;
    logic [SUMSQ_W-1:0]        s3_sumsq_next;
    logic signed [63:0]        prod_sh [4];
    logic [FIELD_W:0]          lane_c [4];

    // square-root pipeline
    logic                      sq_v_reg     [ROOT_W+1];
    carry_t                    sq_pl_reg    [ROOT_W+1];
    logic [SQREM_W-1:0]        sq_rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0]         sq_root_reg  [ROOT_W+1];
    carry_t                    sq0_pl_next;
    logic signed [65:0]        dot_sh;
    logic [FIELD_W:0]          dot_c;
    logic [SQREM_W-1:0]        sq_rem_next  [ROOT_W+1];
    logic [ROOT_W-1:0]         sq_root_next [ROOT_W+1];

    // divider pipeline
    logic                      dv_v_reg   [NUM_W+1];
    carry_t                    dv_pl_reg  [NUM_W+1];
    logic [ROOT_W-1:0]         dv_m_reg   [NUM_W+1];
    logic [NUM_W-1:0]          dv_num_reg [NUM_W+1][4];
    logic [NUM_W-1:0]          dv_q_reg   [NUM_W+1][4];
    logic [ROOT_W:0]           dv_rem_reg [NUM_W+1][4];
    carry_t                    dv0_pl_next;
    logic [FIELD_W:0]          mag_c;
    logic [FIELD_W-1:0]        a_abs [4];
    logic [NUM_W-1:0]          dv_q_next   [NUM_W+1][4];
    logic [ROOT_W:0]           dv_rem_next [NUM_W+1][4];

    // output
    logic                      done_reg;
    out_t                      rsp_reg;
    out_t                      rsp_next;
    logic signed [WIDE_W-1:0]  qw [4];
    logic [FIELD_W:0]          norm_c [4];
    logic [3:0][FIELD_W-1:0]   rv;
    logic [FIELD_W-1:0]        sv;
    logic                      satv;
    logic [2:0]                tail_cmd;
    logic                      tail_norm_zero;
    logic                      tail_vec;
    logic                      rsp_vec_zero;

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    always_comb
    begin
        a1[0] = s1_reg.a_x; a1[1] = s1_reg.a_y; a1[2] = s1_reg.a_z; a1[3] = s1_reg.a_w;
        b1[0] = s1_reg.b_x; b1[1] = s1_reg.b_y; b1[2] = s1_reg.b_z; b1[3] = s1_reg.b_w;
        for (int i = 0; i < 4; i++)
        begin
            bsel[i]         = (s1_reg.cmd == CMD_SCALE) ? s1_reg.scale_factor : b1[i];
            s2_prod_next[i] = a1[i] * bsel[i];
            s2_sq_full[i]   = a1[i] * a1[i];
            s2_sq_next[i]   = s2_sq_full[i][62:0];
            s2_sum_next[i]  = (s1_reg.cmd == CMD_SUB) ? a1[i] - b1[i] : a1[i] + b1[i];
        end
    end

    always_comb
    begin
        s3_next     = '0;
        s3_next.cmd = s2_cmd_reg;
        s3_next.a   = s2_a_reg;
        for (int i = 0; i < 4; i++)
        begin
            prod_sh[i] = s2_prod_reg[i] >>> FRAC_BITS;
            unique case (s2_cmd_reg)
                CMD_ADD, CMD_SUB:   lane_c[i] = sat_clamp(WIDE_W'(s2_sum_reg[i]), COMPONENT_BITS);
                CMD_SCALE, CMD_MUL: lane_c[i] = sat_clamp(WIDE_W'(prod_sh[i]), COMPONENT_BITS);
                default:            lane_c[i] = '0;
            endcase
            s3_next.r[i] = lane_c[i][FIELD_W-1:0];
        end
        s3_next.sat   = lane_c[0][FIELD_W] | lane_c[1][FIELD_W] |
                        lane_c[2][FIELD_W] | lane_c[3][FIELD_W];
        s3_dot_next   = 66'(s2_prod_reg[0]) + 66'(s2_prod_reg[1]) +
                        66'(s2_prod_reg[2]) + 66'(s2_prod_reg[3]);
        s3_sumsq_next = SUMSQ_W'(s2_sq_reg[0]) + SUMSQ_W'(s2_sq_reg[1]) +
                        SUMSQ_W'(s2_sq_reg[2]) + SUMSQ_W'(s2_sq_reg[3]);
    end

    // dot result joins the carried payload as the root pipeline starts
    always_comb
    begin
        dot_sh      = s3_dot_reg >>> FRAC_BITS;
        dot_c       = sat_clamp(WIDE_W'(dot_sh), COMPONENT_BITS);
        sq0_pl_next = s3_reg;
        if (s3_reg.cmd == CMD_DOT)
        begin
            sq0_pl_next.s   = dot_c[FIELD_W-1:0];
            sq0_pl_next.sat = dot_c[FIELD_W];
        end
    end

    // one root bit per stage: try q + 2^j against the remainder x - q^2
    always_comb
    begin
        logic [SQREM_W-1:0] delta;
        int                 j;
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        for (int k = 0; k < ROOT_W; k++)
        begin
            j     = ROOT_W - 1 - k;
            delta = (SQREM_W'(sq_root_reg[k]) << (j + 1)) | (SQREM_W'(1) << (2 * j));
            if (sq_rem_reg[k] >= delta)
            begin
                sq_rem_next[k+1]  = sq_rem_reg[k] - delta;
                sq_root_next[k+1] = sq_root_reg[k] | (ROOT_W'(1) << j);
            end
            else
            begin
                sq_rem_next[k+1]  = sq_rem_reg[k];
                sq_root_next[k+1] = sq_root_reg[k];
            end
        end
    end

    always_comb
    begin
        mag_c       = sat_clamp(WIDE_W'(sq_root_reg[ROOT_W]), COMPONENT_BITS);
        dv0_pl_next = sq_pl_reg[ROOT_W];
        if (sq_pl_reg[ROOT_W].cmd == CMD_MAG)
        begin
            dv0_pl_next.s   = mag_c[FIELD_W-1:0];
            dv0_pl_next.sat = mag_c[FIELD_W];
        end
        for (int i = 0; i < 4; i++)
        begin
            a_abs[i] = sq_pl_reg[ROOT_W].a[i][FIELD_W-1] ?
                       (~sq_pl_reg[ROOT_W].a[i] + FIELD_W'(1)) : sq_pl_reg[ROOT_W].a[i];
        end
    end

    // restoring division, one quotient bit per stage and lane
    always_comb
    begin
        logic [ROOT_W:0] t;
        int              j;
        for (int i = 0; i < 4; i++)
        begin
            dv_q_next[0][i]   = '0;
            dv_rem_next[0][i] = '0;
        end
        for (int k = 0; k < NUM_W; k++)
        begin
            j = NUM_W - 1 - k;
            for (int i = 0; i < 4; i++)
            begin
                t = {dv_rem_reg[k][i][ROOT_W-1:0], dv_num_reg[k][i][j]};
                if (t >= {1'b0, dv_m_reg[k]})
                begin
                    dv_rem_next[k+1][i] = t - {1'b0, dv_m_reg[k]};
                    dv_q_next[k+1][i]   = dv_q_reg[k][i] | (NUM_W'(1) << j);
                end
                else
                begin
                    dv_rem_next[k+1][i] = t;
                    dv_q_next[k+1][i]   = dv_q_reg[k][i];
                end
            end
        end
    end

    always_comb
    begin
        rv   = dv_pl_reg[NUM_W].r;
        sv   = dv_pl_reg[NUM_W].s;
        satv = dv_pl_reg[NUM_W].sat;
        for (int i = 0; i < 4; i++)
        begin
            qw[i] = $signed(WIDE_W'(dv_q_reg[NUM_W][i]));
            // floor toward negative infinity for a negative dividend
            if (dv_pl_reg[NUM_W].a[i][FIELD_W-1])
            begin
                qw[i] = -qw[i] - WIDE_W'(dv_rem_reg[NUM_W][i] != '0);
            end
            norm_c[i] = sat_clamp(qw[i], COMPONENT_BITS);
        end
        if (dv_pl_reg[NUM_W].cmd == CMD_NORM && dv_m_reg[NUM_W] != '0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rv[i] = norm_c[i][FIELD_W-1:0];
            end
            satv = norm_c[0][FIELD_W] | norm_c[1][FIELD_W] |
                   norm_c[2][FIELD_W] | norm_c[3][FIELD_W];
        end
        rsp_next.r_x        = rv[0];
        rsp_next.r_y        = rv[1];
        rsp_next.r_z        = rv[2];
        rsp_next.r_w        = rv[3];
        rsp_next.scalar_out = sv;
        rsp_next.saturated  = satv;
    end

    assign tail_cmd       = dv_pl_reg[NUM_W].cmd;
    assign tail_norm_zero = (tail_cmd == CMD_NORM) && (dv_m_reg[NUM_W] == '0);
    assign tail_vec       = (tail_cmd == CMD_ADD) || (tail_cmd == CMD_SUB) ||
                            (tail_cmd == CMD_SCALE) || (tail_cmd == CMD_MUL) ||
                            (tail_cmd == CMD_NORM);
    assign rsp_vec_zero   = (rsp.r_x == '0) && (rsp.r_y == '0) &&
                            (rsp.r_z == '0) && (rsp.r_w == '0);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            for (int k = 0; k <= ROOT_W; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= NUM_W; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg    <= start & ~busy;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            sq_v_reg[0] <= s3_v_reg;
            for (int k = 0; k < ROOT_W; k++)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            dv_v_reg[0] <= sq_v_reg[ROOT_W];
            for (int k = 0; k < NUM_W; k++)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
            done_reg <= dv_v_reg[NUM_W];
        end
    end

    // payload: advance every cycle
    always_ff @(posedge clk)
    begin
        s1_reg     <= req;
        s2_cmd_reg <= s1_reg.cmd;
        s2_a_reg   <= {s1_reg.a_w, s1_reg.a_z, s1_reg.a_y, s1_reg.a_x};
        for (int i = 0; i < 4; i++)
        begin
            s2_prod_reg[i] <= s2_prod_next[i];
            s2_sq_reg[i]   <= s2_sq_next[i];
            s2_sum_reg[i]  <= s2_sum_next[i];
        end
        s3_reg         <= s3_next;
        s3_dot_reg     <= s3_dot_next;
        s3_sumsq_reg   <= s3_sumsq_next;
        sq_pl_reg[0]   <= sq0_pl_next;
        sq_rem_reg[0]  <= SQREM_W'(s3_sumsq_reg);
        sq_root_reg[0] <= '0;
        for (int k = 0; k < ROOT_W; k++)
        begin
            sq_pl_reg[k+1]   <= sq_pl_reg[k];
            sq_rem_reg[k+1]  <= sq_rem_next[k+1];
            sq_root_reg[k+1] <= sq_root_next[k+1];
        end
        dv_pl_reg[0] <= dv0_pl_next;
        dv_m_reg[0]  <= sq_root_reg[ROOT_W];
        for (int i = 0; i < 4; i++)
        begin
            dv_num_reg[0][i] <= {a_abs[i], FRAC_BITS'(0)};
            dv_q_reg[0][i]   <= '0;
            dv_rem_reg[0][i] <= '0;
        end
        for (int k = 0; k < NUM_W; k++)
        begin
            dv_pl_reg[k+1] <= dv_pl_reg[k];
            dv_m_reg[k+1]  <= dv_m_reg[k];
            for (int i = 0; i < 4; i++)
            begin
                dv_num_reg[k+1][i] <= dv_num_reg[k][i];
                dv_q_reg[k+1][i]   <= dv_q_next[k+1][i];
                dv_rem_reg[k+1][i] <= dv_rem_next[k+1][i];
            end
        end
        rsp_reg <= rsp_next;
    end

    `VFA_ASSERT_DELAY(a_fixed_latency, start && !busy, LAT, done, "result beat missing")
    `VFA_ASSERT_NEXT(a_norm_zero, dv_v_reg[NUM_W] && tail_norm_zero, rsp_vec_zero && !rsp.saturated, "zero vector not passed through")
    `VFA_ASSERT_NEXT(a_vec_scalar_zero, dv_v_reg[NUM_W] && tail_vec, rsp.scalar_out == '0, "scalar set on vector command")

endmodule

`default_nettype wire
